// ===== rtl/xrbm_pkg.sv =====
// package for the xorshift random-below-modulus unit
// shared constants and the divider cell's control struct; no dependencies
`default_nettype none
package xrbm_pkg;
   localparam int unsigned WordWidth = 64;
   localparam logic [63:0] ResetMarkA  = 64'h0000_0000_1234_5678;
   localparam logic [63:0] ResetValueB = 64'h0000_0000_ABCD_EF01;
   localparam logic [63:0] SeedXorMask = 64'h5555_5555_5555_5555;
   localparam int unsigned ShiftA = 23;
   localparam int unsigned ShiftB = 17;
   localparam int unsigned ShiftC = 26;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// ===== rtl/xrbm_div_cell.sv =====
// one bit cell of the restoring remainder chain
// holds one dividend bit and one remainder bit; uses xrbm_pkg
`default_nettype none
module xrbm_div_cell (
   input  wire                    clock,
   input  xrbm_pkg::cell_ctrl_type ctrl,
   input  wire                    load_bit,
   input  wire                    dvd_from_right,
   input  wire                    rem_from_right,
   input  wire                    sub_bit,
   input  wire                    take_sub,
   output logic                   dvd_bit,
   output logic                   rem_bit
);
   import xrbm_pkg::*;
   logic dvd_ff, dvd_in, rem_ff, rem_in;
   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (ctrl.load) begin
         dvd_in = load_bit;
         rem_in = 1'b0;
      end else if (ctrl.step) begin
         dvd_in = dvd_from_right;
         rem_in = take_sub ? sub_bit : rem_from_right;
      end
   end
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end
   assign dvd_bit = dvd_ff;
   assign rem_bit = rem_ff;
endmodule
`default_nettype wire

// ===== rtl/xorshift_random_below_modulus_unit.sv =====
// a nonzero modulus passes through the generator state, the shift-subtract state
// in the bit-cell chain and a fix-up state before the response; a zero modulus is
// answered straight from idle; one request at a time and a new one only after the
// response transaction
// the remainder chain has 64 bit cells
// synchronous reset loads the marker and reset value into the generator words, clears seed and control
`default_nettype none
module xorshift_random_below_modulus_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [63:0] modulus
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] random_value
   output logic        rsp_tuser,   // [0] result_valid
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [63:0] csr_data
);
   import xrbm_pkg::*;
   localparam logic [1:0] StIdle = 2'd0, StGen = 2'd1, StDiv = 2'd2, StFix = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [63:0] seed_ff, wa_ff, wa_in, wb_ff, wb_in, mod_ff, draw_ff, draw_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        rv_ff, rv_in;
   logic [63:0] rd_ff, rd_in;
   logic        ru_ff, ru_in;
   logic [63:0] dvd, rem;
   logic [64:0] shifted, diff;
   logic        take;
   cell_ctrl_type ctrl;
   logic [63:0] sa, sb, x, nb;
   logic        fire;

   assign fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle) && !rv_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      sa = wa_ff; sb = wb_ff;
      if (wa_ff == ResetMarkA) begin
         sa = seed_ff; sb = seed_ff ^ SeedXorMask;
      end
      x  = sa ^ (sa << ShiftA);
      nb = x ^ sb ^ (x >> ShiftB) ^ (sb >> ShiftC);
   end

   assign shifted = {rem, dvd[63]};
   assign diff    = shifted - {1'b0, mod_ff};
   assign take    = !diff[64];
   assign ctrl    = '{load: (state_ff == StGen), step: (state_ff == StDiv)};

   genvar gi;
   generate
      for (gi = 0; gi < 64; gi++) begin : g_cell
         xrbm_div_cell u_cell (
            .clock(clock), .ctrl(ctrl), .load_bit(draw_in[gi]),
            .dvd_from_right(gi == 0 ? 1'b0 : dvd[(gi == 0) ? 0 : gi - 1]),
            .rem_from_right(shifted[gi]), .sub_bit(diff[gi]), .take_sub(take),
            .dvd_bit(dvd[gi]), .rem_bit(rem[gi]));
      end
   endgenerate

   always_comb begin
      state_in = state_ff; wa_in = wa_ff; wb_in = wb_ff; draw_in = draw_ff;
      cnt_in = cnt_ff; rv_in = rv_ff; rd_in = rd_ff; ru_in = ru_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         StIdle: if (fire) begin
            if (req_tdata == 64'd0) begin
               rv_in = 1'b1; rd_in = 64'd0; ru_in = 1'b0;
            end else state_in = StGen;
         end
         StGen: begin
            wa_in = sb; wb_in = nb; draw_in = nb + sb;
            cnt_in = 7'd0; state_in = StDiv;
         end
         StDiv: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = StFix;
         end
         StFix: begin
            rv_in = 1'b1; ru_in = 1'b1;
            rd_in = (rem == 64'd0) ? 64'd1 : rem;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; rv_ff <= 1'b0; seed_ff <= 64'd0;
         wa_ff <= ResetMarkA; wb_ff <= ResetValueB;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; wa_ff <= wa_in; wb_ff <= wb_in;
         if (csr_valid && csr_ready) seed_ff <= csr_data;
      end
      if (fire) mod_ff <= req_tdata;
      draw_ff <= draw_in; cnt_ff <= cnt_in; rd_ff <= rd_in; ru_ff <= ru_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> !req_tready) else $error("accept while busy");
   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata != 64'd0)) else $error("zero value");
   a_gen_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StGen) |=> (state_ff == StDiv)) else $error("bad sequence");
`endif
endmodule
`default_nettype wire

// ===== test/xorshift_random_below_modulus_unit_checker.sv =====
// checker for the xorshift random-below-modulus unit: watches seed writes,
// requests and responses, predicts each response and compares; needs xrbm_pkg
`timescale 1ns / 100ps
`default_nettype none
module xorshift_random_below_modulus_unit_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [63:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [63:0] rsp_tdata,
   input  wire         rsp_tuser,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [63:0] csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          response_count
);
   import xrbm_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        valid;
   } draw_type;

   logic [63:0] seed_reg, word_a, word_b;
   draw_type    draw_queue[$];

   assign pending_count = draw_queue.size();

   function automatic draw_type predict_draw(logic [63:0] modulus);
      draw_type    d;
      logic [63:0] x, y, sum;
      d = '0;
      if (modulus != 0) begin
         if (word_a == ResetMarkA) begin
            word_a = seed_reg;
            word_b = seed_reg ^ SeedXorMask;
         end
         x = word_a;
         y = word_b;
         x = x ^ (x << ShiftA);
         word_a = y;
         word_b = x ^ y ^ (x >> ShiftB) ^ (y >> ShiftC);
         sum = word_b + y;
         d.value = sum % modulus;
         if (d.value == 0) d.value = 1;
         d.valid = 1'b1;
      end
      return d;
   endfunction

   always @(posedge clock) begin
      draw_type d;
      if (reset) begin
         seed_reg <= '0;
         word_a = ResetMarkA;
         word_b = ResetValueB;
         draw_queue.delete();
         fail_count <= 0;
         response_count <= 0;
      end else begin
         if (csr_valid && csr_ready) seed_reg <= csr_data;
         if (rsp_tvalid && rsp_tready) begin
            response_count <= response_count + 1;
            if (draw_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               d = draw_queue.pop_front();
               if (d.value !== rsp_tdata || d.valid !== rsp_tuser) begin
                  if (fail_count < 10)
                     $display("mismatch: expected value %h valid %b, got %h %b",
                              d.value, d.valid, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) draw_queue.push_back(predict_draw(req_tdata));
      end
   end

   initial begin
      fail_count = 0;
      response_count = 0;
   end
endmodule
`default_nettype wire

// ===== test/xorshift_random_below_modulus_unit_tb.sv =====
// testbench top for the xorshift random-below-modulus unit: drives seed writes
// and requests with random gaps, stalls responses; relies on the checker module
`timescale 1ns / 100ps
`default_nettype none
module xorshift_random_below_modulus_unit_tb;
   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [63:0] req_tdata = '0, csr_data = '0;
   wire         req_tready, rsp_tvalid, rsp_tuser, csr_ready;
   wire  [63:0] rsp_tdata;
   int          fail_count, pending_count, response_count;
   int          modulus_count = 0, zero_count = 0, stall_cycles = 0;
   bit          hold_off = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   xorshift_random_below_modulus_unit u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_data
   );

   xorshift_random_below_modulus_unit_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_data,
      .fail_count, .pending_count, .response_count
   );

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] random_modulus();
      int pick;
      logic [63:0] m;
      pick = $urandom_range(0, 9);
      m = random_word();
      case (pick)
         0: m = 0;
         1: m = $urandom_range(1, 3);
         2: m = m >> $urandom_range(1, 62);
         3: m = '1 - $urandom_range(0, 3);
         default: ;
      endcase
      return m;
   endfunction

   task automatic send_request(logic [63:0] modulus);
      repeat ($urandom_range(0, 11)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = modulus;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      modulus_count++;
      if (modulus == 0) zero_count++;
   endtask

   task automatic write_seed(logic [63:0] seed);
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= seed;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response side: random stalls, plus one long hold-off when asked
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      logic [63:0] seeds[6];
      seeds = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678, 64'h0, 64'h0, 64'h0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset seed of zero, then extremes of the modulus
      send_request(64'h0);
      send_request(64'h1);
      send_request(64'h2);
      send_request('1);
      send_request(64'h8000_0000_0000_0000);
      send_request(64'h0);
      send_request(64'h7);
      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      repeat (4) send_request(random_modulus());
      // seed equal to the marker value
      write_seed(64'h1234_5678);
      repeat (4) send_request(random_modulus());
      send_request(64'h0);
      hold_off = 1;
      repeat (6) send_request(random_modulus());
      for (int phase = 0; phase < 5; phase++) begin
         seeds[3 + (phase % 3)] = random_word();
         write_seed(phase == 4 ? 64'h0 : random_word());
         repeat (200) send_request(random_modulus());
      end
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("requests %0d (zero modulus %0d), responses %0d, seeds incl. 0 and all ones",
               modulus_count, zero_count, response_count);
      if (fail_count == 0) begin
         $display("xorshift_random_below_modulus_unit test passed");
      end else begin
         $display("xorshift_random_below_modulus_unit test failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("xorshift_random_below_modulus_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire
